FILE: rtl/core/fbfa_pkg.sv
`timescale 1ns / 1ps

package fbfa_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned MAX_BLOCKS = 512;
  localparam int unsigned MIN_BLOCK  = 8;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned BSZ_W  = 13;
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned DIV_W  = 13;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_OFF = 2'd2;

  localparam logic [ADDR_W-1:0] REG_BLOCK_SIZE = 3'd0;

  localparam logic [CNT_W-1:0] END_MARK = CNT_W'(MAX_BLOCKS);
  localparam logic [BSZ_W-1:0] BSZ_MIN  = BSZ_W'(MIN_BLOCK);
  localparam logic [BSZ_W-1:0] BSZ_RST  = 13'd32;
  localparam logic [DIV_W-1:0] PAGE_DVD = DIV_W'(PAGE_BYTES);

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [OFF_W-1:0] free_offset;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  block_offset;
    logic [CNT_W-1:0]  free_blocks;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LINK,
    ST_READ,
    ST_DONE
  } fsm_t;

endpackage

FILE: rtl/core/fixed_block_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// path to out_valid: alloc via ST_READ, ST_DONE (ST_DONE alone on an empty pool),
// unused cmd via ST_DONE, free via ST_DIV, ST_DONE, init via ST_DIV, [ST_LINK], ST_DONE
// one item at a time: the 13-step shared divider and the init link walk set the pace
// a new beat is taken only in ST_IDLE, and ST_DONE waits while the held result is stalled
// reset (rst_n low, synchronous): empty pool, no blocks, block size 32, no beat pending

module fixed_block_free_list_allocator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  fbfa_pkg::in_beat_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fbfa_pkg::out_beat_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbfa_pkg::ADDR_W-1:0]  paddr,
  input  logic [fbfa_pkg::DATA_W-1:0]  pwdata,
  output logic [fbfa_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [fbfa_pkg::BSZ_W-1:0] blk_bytes_r, blk_bytes_nxt;
  logic                       reg_hit;
  fbfa_pkg::div_req_t         div_req;
  fbfa_pkg::div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[fbfa_pkg::ADDR_W-1:2] ==
                    fbfa_pkg::REG_BLOCK_SIZE[fbfa_pkg::ADDR_W-1:2]);

  always_comb begin
    blk_bytes_nxt = blk_bytes_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      blk_bytes_nxt = pwdata[fbfa_pkg::BSZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_bytes_r <= fbfa_pkg::BSZ_RST;
    end else begin
      blk_bytes_r <= blk_bytes_nxt;
    end
  end

  assign prdata = reg_hit ? fbfa_pkg::DATA_W'(blk_bytes_r) : '0;

  fbfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  fbfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .blk_bytes  (blk_bytes_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );

endmodule

FILE: rtl/core/fbfa_div.sv
`timescale 1ns / 1ps

module fbfa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fbfa_pkg::div_req_t req,
  output fbfa_pkg::div_rsp_t rsp
);

  logic [fbfa_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [fbfa_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [fbfa_pkg::DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [fbfa_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [fbfa_pkg::DIV_W:0]    shifted;
  logic [fbfa_pkg::DIV_W:0]    trial;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_r, quo_r[fbfa_pkg::DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = fbfa_pkg::STEP_W'(fbfa_pkg::DIV_W);
    end else if (cnt_r != '0) begin
      if (trial[fbfa_pkg::DIV_W]) begin
        rem_nxt = shifted[fbfa_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[fbfa_pkg::DIV_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[fbfa_pkg::DIV_W-1:0];
        quo_nxt = {quo_r[fbfa_pkg::DIV_W-2:0], 1'b1};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == fbfa_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: rtl/core/fbfa_ctrl.sv
`timescale 1ns / 1ps

module fbfa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fbfa_pkg::BSZ_W-1:0]  blk_bytes,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fbfa_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fbfa_pkg::out_beat_t         out_data,
  output fbfa_pkg::div_req_t          div_req,
  input  fbfa_pkg::div_rsp_t          div_rsp
);

  fbfa_pkg::fsm_t                state_r, state_nxt;
  logic [fbfa_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [fbfa_pkg::CNT_W-1:0]    head_r, head_nxt;
  logic [fbfa_pkg::CNT_W-1:0]    free_r, free_nxt;
  logic [fbfa_pkg::CNT_W-1:0]    total_r, total_nxt;
  logic [fbfa_pkg::BSZ_W-1:0]    pool_r, pool_nxt;
  logic [fbfa_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [fbfa_pkg::OFF_W-1:0]    res_off_r, res_off_nxt;
  logic [fbfa_pkg::STAT_W-1:0]   stat_r, stat_nxt;
  logic                          out_valid_r, out_valid_nxt;
  fbfa_pkg::out_beat_t           out_data_r, out_data_nxt;

  logic [fbfa_pkg::CNT_W-1:0]    link_mem [fbfa_pkg::MAX_BLOCKS];
  logic [fbfa_pkg::CNT_W-1:0]    rd_r;
  logic                          mem_we;
  logic [fbfa_pkg::IDX_W-1:0]    mem_wa;
  logic [fbfa_pkg::CNT_W-1:0]    mem_wd;

  logic [fbfa_pkg::BSZ_W-1:0]    pool_in;
  logic [22:0]                   prod;
  logic [fbfa_pkg::CNT_W-1:0]    n_blocks;
  logic [fbfa_pkg::CNT_W-1:0]    idx_inc;
  logic                          accept;

  assign pool_in  = (blk_bytes < fbfa_pkg::BSZ_MIN) ? fbfa_pkg::BSZ_MIN : blk_bytes;
  assign prod     = 23'(head_r) * 23'(pool_r);
  assign n_blocks = (div_rsp.quotient > fbfa_pkg::DIV_W'(fbfa_pkg::MAX_BLOCKS))
                    ? fbfa_pkg::END_MARK : div_rsp.quotient[fbfa_pkg::CNT_W-1:0];
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign in_stall = (state_r != fbfa_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    total_nxt     = total_r;
    pool_nxt      = pool_r;
    idx_nxt       = idx_r;
    res_off_nxt   = res_off_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_req       = '0;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = fbfa_pkg::END_MARK;
    case (state_r)
      fbfa_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_data.cmd;
          stat_nxt    = fbfa_pkg::STAT_OK;
          res_off_nxt = '0;
          case (in_data.cmd)
            fbfa_pkg::CMD_INIT: begin
              pool_nxt         = pool_in;
              div_req.start    = 1'b1;
              div_req.dividend = fbfa_pkg::PAGE_DVD;
              div_req.divisor  = pool_in;
              state_nxt        = fbfa_pkg::ST_DIV;
            end
            fbfa_pkg::CMD_ALLOC: begin
              if (free_r == '0 || head_r >= total_r) begin
                stat_nxt  = fbfa_pkg::STAT_EMPTY;
                state_nxt = fbfa_pkg::ST_DONE;
              end else begin
                res_off_nxt = prod[fbfa_pkg::OFF_W-1:0];
                state_nxt   = fbfa_pkg::ST_READ;
              end
            end
            fbfa_pkg::CMD_FREE: begin
              div_req.start    = 1'b1;
              div_req.dividend = {1'b0, in_data.free_offset};
              div_req.divisor  = pool_r;
              state_nxt        = fbfa_pkg::ST_DIV;
            end
            default: begin
              state_nxt = fbfa_pkg::ST_DONE;
            end
          endcase
        end
      end
      fbfa_pkg::ST_READ: begin
        head_nxt  = rd_r;
        free_nxt  = free_r - 1'b1;
        state_nxt = fbfa_pkg::ST_DONE;
      end
      fbfa_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (cmd_r == fbfa_pkg::CMD_INIT) begin
            total_nxt = n_blocks;
            free_nxt  = n_blocks;
            idx_nxt   = '0;
            if (n_blocks != '0) begin
              head_nxt  = '0;
              state_nxt = fbfa_pkg::ST_LINK;
            end else begin
              head_nxt  = fbfa_pkg::END_MARK;
              state_nxt = fbfa_pkg::ST_DONE;
            end
          end else begin
            state_nxt = fbfa_pkg::ST_DONE;
            if (div_rsp.remainder != '0 ||
                div_rsp.quotient >= fbfa_pkg::DIV_W'(total_r)) begin
              stat_nxt = fbfa_pkg::STAT_BAD_OFF;
            end else begin
              mem_we   = 1'b1;
              mem_wa   = div_rsp.quotient[fbfa_pkg::IDX_W-1:0];
              mem_wd   = head_r;
              head_nxt = div_rsp.quotient[fbfa_pkg::CNT_W-1:0];
              if (free_r < total_r) begin
                free_nxt = free_r + 1'b1;
              end
            end
          end
        end
      end
      fbfa_pkg::ST_LINK: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        idx_nxt = idx_inc[fbfa_pkg::IDX_W-1:0];
        if (idx_inc == total_r) begin
          mem_wd    = fbfa_pkg::END_MARK;
          state_nxt = fbfa_pkg::ST_DONE;
        end else begin
          mem_wd = idx_inc;
        end
      end
      fbfa_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = stat_r;
          out_data_nxt.block_offset = res_off_r;
          out_data_nxt.free_blocks  = free_r;
          state_nxt                 = fbfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbfa_pkg::ST_IDLE;
      head_r      <= fbfa_pkg::END_MARK;
      free_r      <= '0;
      total_r     <= '0;
      pool_r      <= fbfa_pkg::BSZ_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      pool_r      <= pool_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    res_off_r  <= res_off_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    rd_r <= link_mem[head_r[fbfa_pkg::IDX_W-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/fbfa_checker.sv
`timescale 1ns / 1ps

module fbfa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input fbfa_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input fbfa_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while one is in flight");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fbfa_pkg::STAT_OK |-> out_data.block_offset == '0)
    else $error("nonzero offset on failed beat");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.free_blocks <= fbfa_pkg::END_MARK)
    else $error("free count out of range");

endmodule

bind fixed_block_free_list_allocator_unit fbfa_checker u_fbfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: test/fixed_block_free_list_allocator_unit_tb.sv
`timescale 1ns / 1ps

class pool_scoreboard;
  int unsigned         reg_blk_bytes;
  int unsigned         pool_size;
  int unsigned         head;
  int unsigned         free_cnt;
  int unsigned         blk_cnt;
  int unsigned         link_mem [fbfa_pkg::MAX_BLOCKS];
  fbfa_pkg::out_beat_t pending [$];
  int unsigned         held [$];
  int                  errors;
  int                  n_beats, n_init, n_grant, n_empty, n_freed, n_rejected;

  function new();
    reg_blk_bytes = fbfa_pkg::BSZ_RST;
    pool_size = fbfa_pkg::MIN_BLOCK;
    head = fbfa_pkg::MAX_BLOCKS;
    free_cnt = 0;
    blk_cnt = 0;
    errors = 0;
    n_beats = 0;
    n_init = 0;
    n_grant = 0;
    n_empty = 0;
    n_freed = 0;
    n_rejected = 0;
    foreach (link_mem[i]) link_mem[i] = 0;
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // predict the result of one accepted beat
  function void note_beat(fbfa_pkg::in_beat_t b);
    fbfa_pkg::out_beat_t exp_beat;
    int unsigned         off;
    int unsigned         idx;
    int                  qi [$];
    exp_beat = '0;
    exp_beat.status = fbfa_pkg::STAT_OK;
    n_beats++;
    case (b.cmd)
      fbfa_pkg::CMD_INIT: begin
        pool_size = (reg_blk_bytes < fbfa_pkg::MIN_BLOCK) ? fbfa_pkg::MIN_BLOCK
                                                           : reg_blk_bytes;
        blk_cnt = fbfa_pkg::PAGE_BYTES / pool_size;
        if (blk_cnt > fbfa_pkg::MAX_BLOCKS) blk_cnt = fbfa_pkg::MAX_BLOCKS;
        for (int i = 0; i < blk_cnt; i++)
          link_mem[i] = (i + 1 < blk_cnt) ? i + 1 : fbfa_pkg::MAX_BLOCKS;
        free_cnt = blk_cnt;
        head = (blk_cnt > 0) ? 0 : fbfa_pkg::MAX_BLOCKS;
        held.delete();
        n_init++;
      end
      fbfa_pkg::CMD_ALLOC: begin
        if (free_cnt == 0 || head >= blk_cnt) begin
          exp_beat.status = fbfa_pkg::STAT_EMPTY;
          n_empty++;
        end else begin
          off = (head * pool_size) & 32'hFFF;
          exp_beat.block_offset = fbfa_pkg::OFF_W'(off);
          head = link_mem[head];
          free_cnt--;
          held.push_back(off);
          n_grant++;
        end
      end
      fbfa_pkg::CMD_FREE: begin
        off = b.free_offset;
        idx = off / pool_size;
        if (off % pool_size != 0 || idx >= blk_cnt) begin
          exp_beat.status = fbfa_pkg::STAT_BAD_OFF;
          n_rejected++;
        end else begin
          link_mem[idx] = head;
          head = idx;
          if (free_cnt < blk_cnt) free_cnt++;
          qi = held.find_first_index(x) with (x == off);
          if (qi.size() != 0) held.delete(qi[0]);
          n_freed++;
        end
      end
      default: ;
    endcase
    exp_beat.free_blocks = fbfa_pkg::CNT_W'(free_cnt);
    pending.push_back(exp_beat);
  endfunction

  task check_beat(fbfa_pkg::out_beat_t got);
    fbfa_pkg::out_beat_t want;
    if (pending.size() == 0) begin
      report($sformatf("result with nothing pending: status %0d offset %0d free %0d",
                       got.status, got.block_offset, got.free_blocks));
    end else begin
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.block_offset !== want.block_offset)
        report($sformatf("block_offset %0d, want %0d", got.block_offset, want.block_offset));
      if (got.free_blocks !== want.free_blocks)
        report($sformatf("free_blocks %0d, want %0d", got.free_blocks, want.free_blocks));
    end
  endtask
endclass

module fixed_block_free_list_allocator_unit_tb;

  localparam logic [fbfa_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 95;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  fbfa_pkg::in_beat_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  fbfa_pkg::out_beat_t           out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [fbfa_pkg::ADDR_W-1:0]   paddr = '0;
  logic [fbfa_pkg::DATA_W-1:0]   pwdata = '0;
  logic [fbfa_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  pool_scoreboard sb = new();

  int unsigned size_plan [12] = '{8, 4096, 0, 24, 8191, 7, 64, 2048, 100, 5000, 8, 16};
  int unsigned burst_left = 0;
  int          n_settings = 0;
  int          quiet_cycles = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int unsigned rx_tick = 0;

  fixed_block_free_list_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic fbfa_pkg::in_beat_t mk_beat(logic [fbfa_pkg::CMD_W-1:0] c,
                                                  int unsigned o);
    fbfa_pkg::in_beat_t b;
    b.cmd = c;
    b.free_offset = fbfa_pkg::OFF_W'(o);
    return b;
  endfunction

  // mostly alloc and free of held blocks, plus double frees, bad offsets and noise
  function automatic fbfa_pkg::in_beat_t make_op();
    fbfa_pkg::in_beat_t b;
    int unsigned        r;
    int unsigned        k;
    int unsigned        idx;
    b.cmd = fbfa_pkg::CMD_ALLOC;
    b.free_offset = fbfa_pkg::OFF_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 2) begin
      b.cmd = fbfa_pkg::CMD_INIT;
    end else if (r < 4) begin
      b.cmd = CMD_NOP;
    end else if (r < 50) begin
      b.cmd = fbfa_pkg::CMD_ALLOC;
    end else if (r < 80 && sb.held.size() != 0) begin
      k = $urandom_range(0, sb.held.size() - 1);
      b.cmd = fbfa_pkg::CMD_FREE;
      b.free_offset = fbfa_pkg::OFF_W'(sb.held[k]);
    end else if (r < 88) begin
      idx = $urandom_range(0, sb.blk_cnt);
      b.cmd = fbfa_pkg::CMD_FREE;
      b.free_offset = fbfa_pkg::OFF_W'(idx * sb.pool_size);
    end else if (r < 94) begin
      idx = $urandom_range(0, sb.blk_cnt);
      b.cmd = fbfa_pkg::CMD_FREE;
      b.free_offset = fbfa_pkg::OFF_W'(idx * sb.pool_size +
                                       $urandom_range(1, sb.pool_size - 1));
    end else begin
      b.cmd = fbfa_pkg::CMD_FREE;
    end
    return b;
  endfunction

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_beat(input fbfa_pkg::in_beat_t b);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_beat(b);
    pace_sender();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbfa_pkg::ADDR_W-1:0] addr,
                           input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= fbfa_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.reg_blk_bytes = value & 32'h1FFF;
    n_settings++;
  endtask

  // receiver stall pattern, with a long hold-off when asked
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(32, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_tick[3:0] < 4'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.pending.size());
      $display("** fixed_block_free_list_allocator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no pool yet, then the reset block size of 32
    send_beat(mk_beat(fbfa_pkg::CMD_ALLOC, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 4095));
    send_beat(mk_beat(CMD_NOP, 4095));
    send_beat(mk_beat(fbfa_pkg::CMD_INIT, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_ALLOC, 4095));
    send_beat(mk_beat(fbfa_pkg::CMD_ALLOC, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 32));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 33));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 4064));
    send_beat(mk_beat(fbfa_pkg::CMD_FREE, 4095));
    send_beat(mk_beat(fbfa_pkg::CMD_ALLOC, 0));
    send_beat(mk_beat(CMD_NOP, 0));
    send_beat(mk_beat(fbfa_pkg::CMD_INIT, 4095));
    send_beat(mk_beat(fbfa_pkg::CMD_ALLOC, 0));
    drain();

    for (int p = 0; p < 12; p++) begin
      write_reg(fbfa_pkg::REG_BLOCK_SIZE, size_plan[p]);
      if (p == 0 || $urandom_range(0, 3) != 0)
        send_beat(mk_beat(fbfa_pkg::CMD_INIT, $urandom_range(0, 4095)));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ((p == 0 || p == 6) && i == 10) hold_asks <= hold_asks + 1;
        send_beat(make_op());
      end
      drain();
    end

    repeat (600) @(posedge clk);

    $display("covered %0d beats over %0d block size settings plus the reset one",
             sb.n_beats, n_settings);
    $display("%0d inits, %0d grants, %0d empty replies, %0d frees, %0d rejected offsets",
             sb.n_init, sb.n_grant, sb.n_empty, sb.n_freed, sb.n_rejected);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** fixed_block_free_list_allocator_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending.size());
      $display("** fixed_block_free_list_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
